// ----- rtl/sppq_pkg.sv -----
// Shared types and constants for the stable priority process queue.
// Operation and status codes, fixed field widths, controller/datapath structs.
// No dependencies.
package sppq_pkg;

  // Fixed field widths
  localparam int OP_W        = 3;
  localparam int ID_W        = 5;
  localparam int PRIO_IN_W   = 8;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 6;

  // Parameter defaults
  localparam int DEF_QUEUE_DEPTH   = 32;
  localparam int DEF_PRIORITY_BITS = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
  localparam logic [OP_W-1:0] OP_PEEK        = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_HEAD = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_ID   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch the input beat and set up the walk
    logic ins_step;  // one step of the tail-to-head insert walk
    logic place;     // write the new entry into its slot
    logic fwd_step;  // one step of the head-to-tail search/compact walk
    logic fwd_done;  // close the forward walk, settle status and count
    logic load_out;  // load the output register
  } sppq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic ins_done;
    logic fwd_done;
  } sppq_stat_t;

endpackage

// ----- rtl/sppq_ctrl.sv -----
// Controller state machine for the stable priority process queue.
// Sequences each operation and drives the handshakes. Depends on sppq_pkg.
module sppq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sppq_pkg::OP_W-1:0]   operation,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sppq_pkg::sppq_cmd_t         cmd,
  input  sppq_pkg::sppq_stat_t        stat
);
  import sppq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_PLACE  = 3'd2;
  localparam logic [2:0] S_FWD    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // One operation in flight at a time
  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          unique case (operation)
            OP_INSERT:      state_next = stat.full ? S_FINISH : S_INS;
            OP_PEEK,
            OP_REMOVE_HEAD,
            OP_REMOVE_ID:   state_next = S_FWD;
            default:        state_next = S_FINISH;
          endcase
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (stat.ins_done) state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_FINISH;
      end
      S_FWD: begin
        if (stat.fwd_done) begin
          cmd.fwd_done = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.fwd_step = 1'b1;
        end
      end
      S_FINISH: begin
        // output register free or being emptied this cycle
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_out | (out_valid & out_stall);
    end
  end

endmodule

// ----- rtl/sppq_dp.sv -----
// Datapath for the stable priority process queue: entry memory, walk
// counters, result and output registers. Depends on sppq_pkg.
module sppq_dp #(
  parameter int QUEUE_DEPTH   = sppq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = sppq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sppq_pkg::sppq_cmd_t               cmd,
  output sppq_pkg::sppq_stat_t              stat,
  input  logic [sppq_pkg::OP_W-1:0]         operation,
  input  logic [sppq_pkg::ID_W-1:0]         process_id,
  input  logic [sppq_pkg::PRIO_IN_W-1:0]    entry_priority,
  output logic [sppq_pkg::STATUS_W-1:0]     status,
  output logic [sppq_pkg::ID_W-1:0]         result_id,
  output logic [sppq_pkg::PRIO_IN_W-1:0]    result_priority,
  output logic                              queue_empty,
  output logic [sppq_pkg::COUNT_OUT_W-1:0]  entry_count
);
  import sppq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = PRIORITY_BITS;

  // Entry memory, slot 0 is the head
  logic [ID_W-1:0] mem_id   [QUEUE_DEPTH];
  logic [PW-1:0]   mem_prio [QUEUE_DEPTH];

  logic [CW-1:0]       count;
  logic [OP_W-1:0]     lat_op;
  logic [ID_W-1:0]     lat_id;
  logic [PW-1:0]       lat_prio;
  logic [AW-1:0]       idx;
  logic                rd_more;
  logic                pv;
  logic [AW-1:0]       paddr;
  logic [AW-1:0]       place;
  logic                found;
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;
  logic [PW-1:0]       res_prio;
  logic [ID_W-1:0]     rd_id;
  logic [PW-1:0]       rd_prio;

  logic                mem_re;
  logic                mem_we;
  logic [AW-1:0]       wa;
  logic [ID_W-1:0]     wd_id;
  logic [PW-1:0]       wd_prio;
  logic                lower;
  logic                last_rd;
  logic                shift_en;
  logic                match;

  // Walk status
  assign lower    = (rd_prio < lat_prio);
  assign last_rd  = ((CW'(idx) + CW'(1)) == count);
  assign shift_en = (lat_op != OP_PEEK);
  assign match    = (lat_op == OP_REMOVE_ID) ? (rd_id == lat_id) : (paddr == '0);

  assign stat.full     = (count == CW'(QUEUE_DEPTH));
  assign stat.ins_done = (pv && (!lower || paddr == '0)) || (!pv && !rd_more);
  assign stat.fwd_done = !pv && !rd_more;

  // Memory port control: one read and one write per cycle
  assign mem_re = (cmd.ins_step || cmd.fwd_step) && rd_more;

  always_comb begin
    mem_we  = 1'b0;
    wa      = place;
    wd_id   = rd_id;
    wd_prio = rd_prio;
    priority if (cmd.place) begin
      mem_we  = 1'b1;
      wd_id   = lat_id;
      wd_prio = lat_prio;
    end else if (cmd.ins_step && pv && lower) begin
      // move a lower entry one slot toward the tail
      mem_we = 1'b1;
      wa     = paddr + AW'(1);
    end else if (cmd.fwd_step && pv && found && shift_en) begin
      // close the gap left by the removed entry
      mem_we = 1'b1;
      wa     = paddr - AW'(1);
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_id[wa]   <= wd_id;
      mem_prio[wa] <= wd_prio;
    end
    if (mem_re) begin
      rd_id   <= mem_id[idx];
      rd_prio <= mem_prio[idx];
    end
  end

  // Walk control and count
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_more <= 1'b0;
      pv      <= 1'b0;
      found   <= 1'b0;
    end else begin
      priority if (cmd.start) begin
        pv      <= 1'b0;
        found   <= 1'b0;
        rd_more <= (count != '0);
        idx     <= (operation == OP_INSERT) ? AW'(count - CW'(1)) : '0;
        if (operation == OP_CLEAR) count <= '0;
      end else if (cmd.ins_step || cmd.fwd_step) begin
        pv <= rd_more;
        if (rd_more) begin
          paddr <= idx;
          if (cmd.ins_step) begin
            if (idx == '0) rd_more <= 1'b0;
            else           idx     <= idx - AW'(1);
          end else begin
            if (last_rd) rd_more <= 1'b0;
            else         idx     <= idx + AW'(1);
          end
        end
        if (cmd.fwd_step && pv && !found && match) found <= 1'b1;
      end else if (cmd.place) begin
        count <= count + CW'(1);
      end else if (cmd.fwd_done) begin
        if (found && shift_en) count <= count - CW'(1);
      end
    end
  end

  // Latched request, insert slot and result
  always_ff @(posedge clk) begin
    priority if (cmd.start) begin
      lat_op     <= operation;
      lat_id     <= process_id;
      lat_prio   <= PW'(entry_priority);
      place      <= AW'(count);
      res_id     <= '0;
      res_prio   <= '0;
      res_status <= (operation == OP_INSERT && stat.full) ? ST_FULL : ST_OK;
    end else if (cmd.ins_step && pv) begin
      place <= lower ? paddr : paddr + AW'(1);
    end else if (cmd.fwd_step && pv && !found && match) begin
      res_id   <= rd_id;
      res_prio <= rd_prio;
    end else if (cmd.fwd_done) begin
      res_status <= found ? ST_OK : ST_EMPTY;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status          <= res_status;
      result_id       <= res_id;
      result_priority <= PRIO_IN_W'(res_prio);
      queue_empty     <= (count == '0);
      entry_count     <= COUNT_OUT_W'(count);
    end
  end

endmodule

// ----- rtl/stable_priority_process_queue.sv -----
// Stable priority process queue. Peek and removals walk every stored entry from
// the head; an insert walks from the tail and its time is set by how far that
// walk runs before it stops. Clear, full insert and unused codes skip the walk.
// The next beat is taken in the cycle after the result loads, later while an
// earlier result is still stalled.
// Synchronous reset empties the queue and drops any pending result; memory is kept.
module stable_priority_process_queue #(
  parameter int QUEUE_DEPTH   = sppq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = sppq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sppq_pkg::OP_W-1:0]         operation,
  input  logic [sppq_pkg::ID_W-1:0]         process_id,
  input  logic [sppq_pkg::PRIO_IN_W-1:0]    entry_priority,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sppq_pkg::STATUS_W-1:0]     status,
  output logic [sppq_pkg::ID_W-1:0]         result_id,
  output logic [sppq_pkg::PRIO_IN_W-1:0]    result_priority,
  output logic                              queue_empty,
  output logic [sppq_pkg::COUNT_OUT_W-1:0]  entry_count
);
  import sppq_pkg::*;

  sppq_cmd_t  cmd;
  sppq_stat_t stat;

  // Sequencer
  sppq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Storage and result path
  sppq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .operation       (operation),
    .process_id      (process_id),
    .entry_priority  (entry_priority),
    .status          (status),
    .result_id       (result_id),
    .result_priority (result_priority),
    .queue_empty     (queue_empty),
    .entry_count     (entry_count)
  );

endmodule

// ----- rtl/sppq_checker.sv -----
// Port-level checks for the stable priority process queue, bound to the
// top level. Depends on sppq_pkg and stable_priority_process_queue.
module sppq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [sppq_pkg::STATUS_W-1:0]     status,
  input logic [sppq_pkg::ID_W-1:0]         result_id,
  input logic [sppq_pkg::PRIO_IN_W-1:0]    result_priority,
  input logic                              queue_empty,
  input logic [sppq_pkg::COUNT_OUT_W-1:0]  entry_count
);
  import sppq_pkg::*;

  // Empty flag agrees with the reported count (when count fits the field)
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && queue_empty |-> entry_count == '0)
    else $error("queue_empty set with nonzero entry_count");

  // Failed operations return no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_id == '0 && result_priority == '0)
    else $error("result fields nonzero on failed operation");

  // Full refusal leaves a non-empty queue
  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> !queue_empty)
    else $error("full status reported on empty queue");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_id)
      && $stable(result_priority) && $stable(entry_count))
    else $error("stalled result beat changed");

endmodule

bind stable_priority_process_queue sppq_checker u_sppq_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .result_id       (result_id),
  .result_priority (result_priority),
  .queue_empty     (queue_empty),
  .entry_count     (entry_count)
);

// ----- tb/stable_priority_process_queue_test.sv -----
// Self-checking testbench for the stable priority process queue.
// Drives operation beats under random gaps and output stalls, predicts each result
// with a local sorted-queue model. Depends only on sppq_pkg and the block itself.
module stable_priority_process_queue_test;
  import sppq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = DEF_QUEUE_DEPTH;
  localparam int PRIO_BITS = DEF_PRIORITY_BITS;
  localparam logic [PRIO_IN_W-1:0] PRIO_MASK = PRIO_IN_W'((64'd1 << PRIO_BITS) - 1);

  // Operation codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_START   = 3000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      id;
    logic [PRIO_IN_W-1:0] prio;
  } op_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ID_W-1:0]        id;
    logic [PRIO_IN_W-1:0]   prio;
    logic                   empty;
    logic [COUNT_OUT_W-1:0] count;
  } queue_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [OP_W-1:0]        operation = '0;
  logic [ID_W-1:0]        process_id = '0;
  logic [PRIO_IN_W-1:0]   entry_priority = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [ID_W-1:0]        result_id;
  logic [PRIO_IN_W-1:0]   result_priority;
  logic                   queue_empty;
  logic [COUNT_OUT_W-1:0] entry_count;

  // Local copy of the queue, head at index 0
  logic [ID_W-1:0]      shadow_ids   [DEPTH];
  logic [PRIO_IN_W-1:0] shadow_prios [DEPTH];
  int                   shadow_count = 0;

  op_beat_t     pending_ops[$];
  queue_reply_t due_replies[$];
  op_beat_t     cur_beat = '0;

  int  total_beats   = 0;
  int  beats_taken   = 0;
  int  mismatches    = 0;
  int  send_gap      = 0;
  int  send_calm     = 0;
  int  stall_left    = 0;
  int  stall_calm    = 0;
  logic hold_off     = 1'b0;

  stable_priority_process_queue DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .process_id      (process_id),
    .entry_priority  (entry_priority),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .result_id       (result_id),
    .result_priority (result_priority),
    .queue_empty     (queue_empty),
    .entry_count     (entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Remove one entry and close the hole
  function automatic void drop_entry(int pos);
    int k;
    for (k = pos; k + 1 < shadow_count; k++) begin
      shadow_ids[k]   = shadow_ids[k + 1];
      shadow_prios[k] = shadow_prios[k + 1];
    end
    shadow_count--;
  endfunction

  // Apply one operation to the local queue and return the reply it must give
  function automatic queue_reply_t apply_queue_op(op_beat_t b);
    queue_reply_t r;
    logic [PRIO_IN_W-1:0] p;
    int pos;
    int k;
    logic found;
    r = '0;
    p = b.prio & PRIO_MASK;
    case (b.op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // stable: goes before the first strictly lower priority
          pos = shadow_count;
          found = 1'b0;
          for (k = 0; k < shadow_count; k++) begin
            if (!found && p > shadow_prios[k]) begin
              pos = k;
              found = 1'b1;
            end
          end
          for (k = shadow_count; k > pos; k--) begin
            shadow_ids[k]   = shadow_ids[k - 1];
            shadow_prios[k] = shadow_prios[k - 1];
          end
          shadow_ids[pos]   = b.id;
          shadow_prios[pos] = p;
          shadow_count++;
        end
      end
      OP_PEEK, OP_REMOVE_HEAD: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id   = shadow_ids[0];
          r.prio = shadow_prios[0];
          if (b.op == OP_REMOVE_HEAD) drop_entry(0);
        end
      end
      OP_REMOVE_ID: begin
        // nearest the head wins among duplicates
        r.status = ST_EMPTY;
        pos = -1;
        for (k = 0; k < shadow_count; k++) begin
          if (pos < 0 && shadow_ids[k] == b.id) pos = k;
        end
        if (pos >= 0) begin
          r.status = ST_OK;
          r.id     = shadow_ids[pos];
          r.prio   = shadow_prios[pos];
          drop_entry(pos);
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.empty = (shadow_count == 0);
    r.count = COUNT_OUT_W'(shadow_count);
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_beat(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                          logic [PRIO_IN_W-1:0] prio);
    op_beat_t b;
    b.op   = op;
    b.id   = id;
    b.prio = prio;
    pending_ops.push_back(b);
    total_beats++;
  endtask

  // Priority draw: a few coarse levels in tie phases, else full range with edges
  function automatic logic [PRIO_IN_W-1:0] pick_prio(logic ties);
    int r;
    if (ties) return PRIO_IN_W'($urandom_range(0, 3) * 85);
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PRIO_IN_W'($urandom_range(0, 255));
  endfunction

  // Random phases: fill, drain, mixed traffic, raw noise
  task automatic build_random_part();
    int counted;
    int kind;
    int len;
    int n;
    int r;
    logic ties;
    logic [OP_W-1:0] op;
    counted = 0;
    kind = 0;
    while (counted < RANDOM_ITEMS) begin
      len  = $urandom_range(20, 60);
      ties = 1'($urandom_range(0, 1));
      if (kind == 0) len = $urandom_range(45, 70);
      for (n = 0; n < len; n++) begin
        r = $urandom_range(0, 99);
        case (kind)
          0: op = (r < 90) ? OP_INSERT : (r < 94) ? OP_PEEK :
                  (r < 97) ? OP_REMOVE_ID : OP_REMOVE_HEAD;
          1: op = (r < 50) ? OP_REMOVE_HEAD : (r < 80) ? OP_REMOVE_ID :
                  (r < 90) ? OP_PEEK : OP_INSERT;
          2: op = (r < 40) ? OP_INSERT : (r < 55) ? OP_PEEK :
                  (r < 75) ? OP_REMOVE_HEAD : (r < 94) ? OP_REMOVE_ID :
                  (r < 97) ? OP_CLEAR : OP_SPARE_A + OP_W'($urandom_range(0, 2));
          default: op = OP_W'($urandom_range(0, 7));
        endcase
        add_beat(op, ID_W'($urandom_range(0, 31)), pick_prio(ties));
        if (op <= OP_CLEAR) counted++;
      end
      r = $urandom_range(0, 99);
      kind = (r < 35) ? 0 : (r < 65) ? 1 : (r < 92) ? 2 : 3;
    end
  endtask

  // Sender: pops the pending list, holds a stalled beat, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_replies.push_back(apply_queue_op(cur_beat));
        beats_taken++;
        if (send_calm > 0) begin
          send_gap = 0;
          send_calm--;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 24) == 0) send_calm = 30;
        end
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_ops.size() != 0) begin
          cur_beat = pending_ops.pop_front();
          in_valid       <= 1'b1;
          operation      <= cur_beat.op;
          process_id     <= cur_beat.id;
          entry_priority <= cur_beat.prio;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted reply against the oldest prediction
  always @(posedge clk) begin
    queue_reply_t got;
    queue_reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {status, result_id, result_priority, queue_empty, entry_count};
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected reply st=%0d id=%0d pr=%0d empty=%0d cnt=%0d",
                     $realtime, got.status, got.id, got.prio, got.empty, got.count);
        end else begin
          want = due_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: reply mismatch exp st=%0d id=%0d pr=%0d empty=%0d cnt=%0d",
                       $realtime, want.status, want.id, want.prio, want.empty,
                       want.count);
              $display("%0t:                got st=%0d id=%0d pr=%0d empty=%0d cnt=%0d",
                       $realtime, got.status, got.id, got.prio, got.empty, got.count);
            end
          end
        end
      end
      // next stall decision
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (stall_calm > 0) begin
        out_stall <= 1'b0;
        stall_calm--;
      end else if ($urandom_range(0, 99) < 70) begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 39) == 0) stall_calm = 40;
      end else begin
        out_stall <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    repeat (HOLD_START) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Overall time limit
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    // empty queue cases
    add_beat(OP_PEEK, 5'd0, 8'd0);
    add_beat(OP_REMOVE_HEAD, 5'd31, 8'd255);
    add_beat(OP_REMOVE_ID, 5'd0, 8'd0);
    // extremes and ties at head, middle and tail
    add_beat(OP_INSERT, 5'd0, 8'd0);
    add_beat(OP_INSERT, 5'd31, 8'd255);
    add_beat(OP_INSERT, 5'd5, 8'd128);
    add_beat(OP_INSERT, 5'd6, 8'd128);
    add_beat(OP_INSERT, 5'd7, 8'd0);
    add_beat(OP_INSERT, 5'd8, 8'd255);
    add_beat(OP_PEEK, 5'd17, 8'd99);
    add_beat(OP_REMOVE_ID, 5'd6, 8'd0);
    add_beat(OP_REMOVE_ID, 5'd20, 8'd0);
    // duplicate id: removal takes the one nearer the head
    add_beat(OP_INSERT, 5'd31, 8'd1);
    add_beat(OP_REMOVE_ID, 5'd31, 8'd0);
    // ignored codes with busy fields
    add_beat(OP_SPARE_A, 5'd31, 8'd255);
    add_beat(OP_SPARE_B, 5'd10, 8'd170);
    add_beat(OP_SPARE_C, 5'd21, 8'd85);
    add_beat(OP_REMOVE_HEAD, 5'd0, 8'd0);
    add_beat(OP_CLEAR, 5'd31, 8'd255);
    add_beat(OP_PEEK, 5'd0, 8'd0);
    add_beat(OP_INSERT, 5'd3, 8'd77);
    add_beat(OP_REMOVE_HEAD, 5'd0, 8'd0);
    build_random_part();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for every beat to be taken and every reply to come back
    while (beats_taken < total_beats) @(posedge clk);
    while (due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sppq_pkg.sv
rtl/sppq_ctrl.sv
rtl/sppq_dp.sv
rtl/stable_priority_process_queue.sv
rtl/sppq_checker.sv
tb/stable_priority_process_queue_test.sv
